### hdl/gfcc_pkg.sv
// Package: constants and types shared by the footprint collision check.
package gfcc_pkg;
    localparam int GRID_MAX_SIDE       = 256;
    localparam int HEADING_SLOTS       = 64;
    localparam int MAX_FOOTPRINT_CELLS = 256;
    localparam int SIDE_W   = $clog2(GRID_MAX_SIDE);
    localparam int HEAD_W   = $clog2(HEADING_SLOTS);
    localparam int SLOT_W   = $clog2(MAX_FOOTPRINT_CELLS);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int MAP_AW   = 2 * SIDE_W;
    localparam int FP_AW    = HEAD_W + SLOT_W;
    localparam int CFG_W    = 9;

    typedef logic [1:0] t_action;
    localparam t_action ACT_MAP   = 2'd0;
    localparam t_action ACT_OFS   = 2'd1;
    localparam t_action ACT_COUNT = 2'd2;
    localparam t_action ACT_QUERY = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              we;
        logic [FP_AW-1:0]  waddr;
        logic [15:0]       wdata;
        logic [FP_AW-1:0]  raddr;
    } t_fp_req;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic              wdata;
        logic [MAP_AW-1:0] raddr;
    } t_map_req;
endpackage

### hdl/grid_footprint_collision_check.sv
// Top level: footprint collision check over an occupancy grid.
//
//  channel | valid       | ready       | payload
//  in      | i_in_valid  | o_in_ready  | i_action .. i_count
//  out     | o_out_valid | i_out_ready | o_collision
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// Writes and count sets do not hold the input. A query holds the input until it is done:
// one count read, then offset and map reads pipelined one per cycle, then the pipeline
// drains, stopping at the first hit.
// Reset clears the per-heading count flags; no clearing pass over any memory.
// A finished result waits in the output register; a new item is taken meanwhile
// only if it is not a query.
module grid_footprint_collision_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic signed [15:0]    i_cell_x,
    input  logic signed [15:0]    i_cell_y,
    input  logic [5:0]            i_heading,
    input  logic [7:0]            i_slot,
    input  logic signed [7:0]     i_cost,
    input  logic signed [7:0]     i_ofs_x,
    input  logic signed [7:0]     i_ofs_y,
    input  logic [8:0]            i_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_collision,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [8:0]            i_cfg_data
);
    import gfcc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  cnt_mem [0:HEADING_SLOTS-1];
    logic [CNT_W-1:0]  r_cnt_rd;
    logic [HEADING_SLOTS-1:0] r_cnt_ok;
    logic              r_n_ok;
    logic [CFG_W-1:0]  r_width, r_height;
    logic              r_out_valid, r_collision;
    logic [HEAD_W-1:0] r_head;
    logic signed [16:0] r_bx, r_by;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic              r_fp_v;
    logic              r_map_v;
    logic              r_hit;

    t_fp_req  fp_req;
    t_map_req map_req;
    logic [15:0] fp_rdata;
    logic        map_rdata;

    gfcc_fp_mem u_fp (.i_clk(i_clk), .i_req(fp_req), .o_rdata(fp_rdata));
    gfcc_map_mem u_map (.i_clk(i_clk), .i_req(map_req), .o_rdata(map_rdata));

    logic acc_in, is_query, fire_out;
    assign is_query   = (i_action == ACT_QUERY);
    assign o_in_ready = (r_state == ST_IDLE) && !(is_query && r_out_valid);
    assign acc_in     = i_in_valid && o_in_ready;
    assign fire_out   = r_out_valid && i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_collision = r_collision;

    // per-heading offset counts
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;
    assign cnt_we    = acc_in && (i_action == ACT_COUNT);
    assign cnt_wdata = (i_count > 9'(MAX_FOOTPRINT_CELLS))
                       ? CNT_W'(MAX_FOOTPRINT_CELLS) : i_count[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[i_heading] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[i_heading];
    end

    logic [SIDE_W:0] w_lim, h_lim;
    assign w_lim = (r_width  > CFG_W'(GRID_MAX_SIDE)) ? (SIDE_W+1)'(GRID_MAX_SIDE)
                                                      : r_width[SIDE_W:0];
    assign h_lim = (r_height > CFG_W'(GRID_MAX_SIDE)) ? (SIDE_W+1)'(GRID_MAX_SIDE)
                                                      : r_height[SIDE_W:0];

    // cell of the offset just read
    logic signed [17:0] cx, cy;
    logic out_rng;
    assign cx = 18'(r_bx) + 18'(signed'(fp_rdata[7:0]));
    assign cy = 18'(r_by) + 18'(signed'(fp_rdata[15:8]));
    assign out_rng = cx[17] || cy[17] || (cx >= 18'(w_lim)) || (cy >= 18'(h_lim));

    logic issue;
    assign issue = (r_state == ST_RUN) && !r_hit && (r_idx < r_n);

    always_comb begin
        fp_req.we    = acc_in && (i_action == ACT_OFS);
        fp_req.waddr = {i_heading, i_slot};
        fp_req.wdata = {i_ofs_y, i_ofs_x};
        fp_req.raddr = {r_head, r_idx[SLOT_W-1:0]};
        map_req.we    = acc_in && (i_action == ACT_MAP) && !i_cell_x[15] && !i_cell_y[15]
                        && (i_cell_x[14:0] < 15'(GRID_MAX_SIDE))
                        && (i_cell_y[14:0] < 15'(GRID_MAX_SIDE));
        map_req.waddr = {i_cell_y[SIDE_W-1:0], i_cell_x[SIDE_W-1:0]};
        map_req.wdata = (i_cost <= 8'sd0);
        map_req.raddr = {cy[SIDE_W-1:0], cx[SIDE_W-1:0]};
    end

    logic hit_now, done;
    assign hit_now = (r_fp_v && out_rng) || (r_map_v && map_rdata);
    assign done = (r_state == ST_RUN) && (r_hit || hit_now || (!issue && !r_fp_v && !r_map_v));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc_in && is_query) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_RUN;
            ST_RUN:  if (done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= CFG_W'(GRID_MAX_SIDE);
            r_height    <= CFG_W'(GRID_MAX_SIDE);
            r_out_valid <= 1'b0;
            r_fp_v      <= 1'b0;
            r_map_v     <= 1'b0;
            r_hit       <= 1'b0;
            r_cnt_ok    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data;
                else r_height <= i_cfg_data;
            end
            if (cnt_we) begin
                r_cnt_ok[i_heading] <= 1'b1;
            end
            if (r_state == ST_LOAD) begin
                r_n <= r_n_ok ? r_cnt_rd : '0;
            end
            if (acc_in && is_query) begin
                r_head <= i_heading;
                r_bx   <= 17'(i_cell_x);
                r_by   <= 17'(i_cell_y);
                r_n_ok <= r_cnt_ok[i_heading];
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_fp_v <= 1'b0;
                r_map_v <= 1'b0;
            end else if (r_state == ST_RUN) begin
                r_fp_v  <= issue && !done;
                r_map_v <= r_fp_v && !out_rng && !done;
                if (issue) r_idx <= r_idx + CNT_W'(1);
                if (hit_now) r_hit <= 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
                r_collision <= r_hit || hit_now;
            end else if (fire_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_in_ready) else $error("item taken during query");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && done) |-> !r_out_valid || fire_out)
        else $error("result overwritten");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_idx <= r_n)) else $error("offset index overrun");
`endif
endmodule

### hdl/gfcc_fp_mem.sv
// Footprint offset memory, one write and one registered read per cycle.
module gfcc_fp_mem (
    input  logic              i_clk,
    input  gfcc_pkg::t_fp_req i_req,
    output logic [15:0]       o_rdata
);
    import gfcc_pkg::*;
    logic [15:0] mem [0:HEADING_SLOTS*MAX_FOOTPRINT_CELLS-1];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end
endmodule

### hdl/gfcc_map_mem.sv
// Obstacle bit map memory, one write and one registered read per cycle.
module gfcc_map_mem (
    input  logic               i_clk,
    input  gfcc_pkg::t_map_req i_req,
    output logic               o_rdata
);
    import gfcc_pkg::*;
    logic mem [0:GRID_MAX_SIDE*GRID_MAX_SIDE-1];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end
endmodule
